### design/hit_time_residual_with_gradient_core_macros.svh
// Assertion macros for the hit time residual core and its checker.
// Depends on nothing; the including module must provide clk and rst_n.
`ifndef HIT_TIME_RESIDUAL_WITH_GRADIENT_CORE_MACROS_SVH
`define HIT_TIME_RESIDUAL_WITH_GRADIENT_CORE_MACROS_SVH

// Same-cycle implication, ignored while reset is asserted.
`define HTRG_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, ignored while reset is asserted.
`define HTRG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also holds across reset.
`define HTRG_ASSERT_ALWAYS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

### design/htrg_pkg.sv
// Shared widths, field types and pipeline stage types of the hit time residual core.
// Used by the core and by its port checker; depends on nothing.
package htrg_pkg;

  localparam int PosW   = 20;                 // position field width
  localparam int TimeW  = 24;                 // time field width
  localparam int DW     = PosW + 1;           // per-axis difference width
  localparam int MagW   = PosW;               // magnitude of a difference
  localparam int DtW    = TimeW + 1;          // hit time minus fit time
  localparam int SqW    = 2 * MagW;           // one squared difference
  localparam int SumW   = SqW + 2;            // sum of three squares
  localparam int NW     = SumW + 16;          // radicand, sum scaled by 2^16
  localparam int RW     = NW / 2;             // root width
  localparam int InvW   = 16;                 // inverse light speed register
  localparam int PrW    = MagW + InvW;        // magnitude times inverse speed
  localparam int NumW   = PrW + 16 + 1;       // dividend with rounding term
  localparam int QW     = 25;                 // slope magnitude width
  localparam int SlW    = 25;                 // slope field width
  localparam int ResW   = TimeW;              // residual field width
  localparam int TpW    = RW + InvW;          // travel product width
  localparam int InW    = 168;                // input tdata width
  localparam int OutW   = 104;                // output tdata width

  localparam logic [InvW-1:0] INV_RESET = 16'd2998;

  typedef struct packed {
    logic [NW-1:0]            n;
    logic [RW:0]              rem;
    logic [RW-1:0]            q;
    logic signed [DtW-1:0]    dt;
    logic [2:0][PrW-1:0]      prod;
    logic [2:0]               sgn;
  } sqrt_stage_t;

  typedef struct packed {
    logic [RW-1:0]            r;
    logic signed [ResW-1:0]   residual;
    logic [2:0][RW-1:0]       rem;
    logic [2:0][QW-1:0]       n;
    logic [2:0][QW-1:0]       q;
    logic [2:0]               sgn;
  } div_stage_t;

endpackage

### design/hit_time_residual_with_gradient_core.sv
// Throughput: one item per cycle while the output is not stalled; the root takes
// one bit per stage over 29 stages and the three slope dividers one quotient bit
// per stage over 25 stages.
// A stall on the output freezes the whole pipeline, so nothing is lost or repeated.
// Reset (synchronous, rst_n low) empties the pipeline and loads inverse light
// speed with 2998.
module hit_time_residual_with_gradient_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // sensor_x, sensor_y, sensor_z, hit_time, fit_x, fit_y, fit_z, fit_time
  input  logic [htrg_pkg::InW-1:0]    in_tdata,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // residual, slope_x, slope_y, slope_z, zero fill
  output logic [htrg_pkg::OutW-1:0]   out_tdata,
  // zero_distance
  output logic                        out_tuser,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [htrg_pkg::InvW-1:0]   cfg_data
);
  import htrg_pkg::*;

  function automatic sqrt_stage_t sqrt_step(input sqrt_stage_t s);
    sqrt_stage_t o;
    logic [RW+2:0] trial;
    logic [RW+2:0] t;
    o     = s;
    trial = {s.rem, s.n[NW-1 -: 2]};
    t     = {1'b0, s.q, 2'b01};
    o.n   = {s.n[NW-3:0], 2'b00};
    if (trial >= t) begin
      o.rem = (RW+1)'(trial - t);
      o.q   = {s.q[RW-2:0], 1'b1};
    end else begin
      o.rem = trial[RW:0];
      o.q   = {s.q[RW-2:0], 1'b0};
    end
    return o;
  endfunction

  function automatic div_stage_t div_step(input div_stage_t s);
    div_stage_t o;
    logic [RW:0] trial;
    o = s;
    for (int k = 0; k < 3; k++) begin
      trial    = {s.rem[k], s.n[k][QW-1]};
      o.n[k]   = {s.n[k][QW-2:0], 1'b0};
      if (trial >= {1'b0, s.r}) begin
        o.rem[k] = RW'(trial - {1'b0, s.r});
        o.q[k]   = {s.q[k][QW-2:0], 1'b1};
      end else begin
        o.rem[k] = trial[RW-1:0];
        o.q[k]   = {s.q[k][QW-2:0], 1'b0};
      end
    end
    return o;
  endfunction

  logic                   ce;
  logic [InvW-1:0]        inv_r;

  // Stage A: differences.
  logic                   a_vld_r;
  logic [2:0][DW-1:0]     a_d_r;
  logic signed [DtW-1:0]  a_dt_r;
  // Stage B: squares and scaled magnitudes.
  logic                   b_vld_r;
  logic [2:0][SqW-1:0]    b_sq_r;
  logic [2:0][PrW-1:0]    b_prod_r;
  logic [2:0]             b_sgn_r;
  logic signed [DtW-1:0]  b_dt_r;
  // Stage C: radicand.
  logic                   c_vld_r;
  sqrt_stage_t            c_r;
  // Root stages.
  logic [RW-1:0]          sq_vld_r;
  sqrt_stage_t            sq_r [RW];
  // Stage D: travel product.
  logic                   d_vld_r;
  logic [TpW-1:0]         d_tp_r;
  logic [RW-1:0]          d_r_r;
  logic signed [DtW-1:0]  d_dt_r;
  logic [2:0][PrW-1:0]    d_prod_r;
  logic [2:0]             d_sgn_r;
  // Stage E: residual and divider setup.
  logic                   e_vld_r;
  div_stage_t             e_r;
  div_stage_t             e_nxt;
  // Divider stages.
  logic [QW-1:0]          dv_vld_r;
  div_stage_t             dv_r [QW];
  // Output register.
  logic                   o_vld_r;
  logic signed [ResW-1:0] o_res_r;
  logic [2:0][SlW-1:0]    o_sl_r;
  logic                   o_zero_r;

  assign ce        = !o_vld_r || out_tready;
  assign in_tready = ce;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_r <= INV_RESET;
    end else if (cfg_valid) begin
      inv_r <= cfg_data;
    end
  end

  // Valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r  <= 1'b0;
      b_vld_r  <= 1'b0;
      c_vld_r  <= 1'b0;
      sq_vld_r <= '0;
      d_vld_r  <= 1'b0;
      e_vld_r  <= 1'b0;
      dv_vld_r <= '0;
      o_vld_r  <= 1'b0;
    end else if (ce) begin
      a_vld_r  <= in_tvalid;
      b_vld_r  <= a_vld_r;
      c_vld_r  <= b_vld_r;
      sq_vld_r <= {sq_vld_r[RW-2:0], c_vld_r};
      d_vld_r  <= sq_vld_r[RW-1];
      e_vld_r  <= d_vld_r;
      dv_vld_r <= {dv_vld_r[QW-2:0], e_vld_r};
      o_vld_r  <= dv_vld_r[QW-1];
    end
  end

  // Stages A to C.
  always_ff @(posedge clk) begin
    if (ce) begin
      for (int k = 0; k < 3; k++) begin
        a_d_r[k] <= {in_tdata[84+20*k+PosW-1], in_tdata[84+20*k +: PosW]}
                  - {in_tdata[20*k+PosW-1], in_tdata[20*k +: PosW]};
      end
      a_dt_r <= $signed({in_tdata[83], in_tdata[60 +: TimeW]})
              - $signed({in_tdata[167], in_tdata[144 +: TimeW]});
    end
  end

  always_ff @(posedge clk) begin
    logic [MagW-1:0] mag;
    if (ce) begin
      for (int k = 0; k < 3; k++) begin
        mag         = a_d_r[k][DW-1] ? MagW'(-a_d_r[k]) : a_d_r[k][MagW-1:0];
        b_sq_r[k]   <= mag * mag;
        b_prod_r[k] <= mag * inv_r;
        b_sgn_r[k]  <= a_d_r[k][DW-1];
      end
      b_dt_r <= a_dt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      c_r.n    <= {SumW'(b_sq_r[0]) + SumW'(b_sq_r[1]) + SumW'(b_sq_r[2]), 16'h0000};
      c_r.rem  <= '0;
      c_r.q    <= '0;
      c_r.dt   <= b_dt_r;
      c_r.prod <= b_prod_r;
      c_r.sgn  <= b_sgn_r;
    end
  end

  // Square root, one result bit per stage.
  for (genvar g = 0; g < RW; g++) begin : g_sqrt
    always_ff @(posedge clk) begin
      if (ce) begin
        sq_r[g] <= sqrt_step((g == 0) ? c_r : sq_r[(g == 0) ? 0 : g-1]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      d_r_r    <= sq_r[RW-1].q;
      d_tp_r   <= sq_r[RW-1].q * inv_r;
      d_dt_r   <= sq_r[RW-1].dt;
      d_prod_r <= sq_r[RW-1].prod;
      d_sgn_r  <= sq_r[RW-1].sgn;
    end
  end

  // Travel time rounds half up; the residual saturates to the field range.
  always_comb begin
    logic [TpW:0]       tsum;
    logic [TimeW-1:0]   travel;
    logic signed [DtW:0] res;
    logic [NumW-1:0]    num;
    tsum   = {1'b0, d_tp_r} + (TpW+1)'(1 << 21);
    travel = tsum[TpW -: TimeW];
    res    = $signed({d_dt_r[DtW-1], d_dt_r}) - $signed({2'b00, travel});
    e_nxt.r = d_r_r;
    if (res > $signed((DtW+1)'(8388607))) begin
      e_nxt.residual = 24'sh7FFFFF;
    end else if (res < $signed(-(DtW+1)'(8388608))) begin
      e_nxt.residual = 24'sh800000;
    end else begin
      e_nxt.residual = res[ResW-1:0];
    end
    for (int k = 0; k < 3; k++) begin
      num            = {1'b0, d_prod_r[k], 16'h0000} + NumW'(d_r_r[RW-1:1]);
      e_nxt.rem[k]   = RW'(num[NumW-1:QW]);
      e_nxt.n[k]     = num[QW-1:0];
      e_nxt.q[k]     = '0;
    end
    e_nxt.sgn = d_sgn_r;
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      e_r <= e_nxt;
    end
  end

  // Slope dividers, one quotient bit per stage on all three axes.
  for (genvar g = 0; g < QW; g++) begin : g_div
    always_ff @(posedge clk) begin
      if (ce) begin
        dv_r[g] <= div_step((g == 0) ? e_r : dv_r[(g == 0) ? 0 : g-1]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      o_res_r  <= dv_r[QW-1].residual;
      o_zero_r <= (dv_r[QW-1].r == '0);
      for (int k = 0; k < 3; k++) begin
        if (dv_r[QW-1].r == '0) begin
          o_sl_r[k] <= '0;
        end else if (dv_r[QW-1].sgn[k]) begin
          o_sl_r[k] <= SlW'(-dv_r[QW-1].q[k]);
        end else begin
          o_sl_r[k] <= SlW'(dv_r[QW-1].q[k]);
        end
      end
    end
  end

  assign out_tvalid = o_vld_r;
  assign out_tdata  = {5'b00000, o_sl_r[2], o_sl_r[1], o_sl_r[0], o_res_r};
  assign out_tuser  = o_zero_r;

endmodule

### design/htrg_checker.sv
// Port-level checker for the hit time residual core, bound to the top level.
// Depends on htrg_pkg and on the assertion macro header.
`include "hit_time_residual_with_gradient_core_macros.svh"

module htrg_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_tready,
  input logic                        out_tvalid,
  input logic                        out_tready,
  input logic [htrg_pkg::OutW-1:0]   out_tdata,
  input logic                        out_tuser
);
  import htrg_pkg::*;

  // The pipeline takes an item exactly when its output register can move.
  `HTRG_ASSERT_NOW(a_ready_follows_out, 1'b1,
    in_tready == (!out_tvalid || out_tready), "in_tready mismatch")
  // A zero distance item carries zero slopes.
  `HTRG_ASSERT_NOW(a_zero_slopes, out_tvalid && out_tuser,
    out_tdata[98:24] == '0, "nonzero slope at zero distance")
  // Reset empties the pipeline.
  `HTRG_ASSERT_ALWAYS(a_reset_empty, !rst_n, !out_tvalid, "result after reset")
  // A stalled result item holds.
  `HTRG_ASSERT_NEXT(a_stall_hold, out_tvalid && !out_tready,
    out_tvalid && $stable(out_tdata) && $stable(out_tuser), "stalled item changed")

endmodule

bind hit_time_residual_with_gradient_core htrg_checker u_htrg_checker (.*);
